// File: src/tcw_pkg.sv
// Package: shared types, constants and address helpers for the text console writer.
package tcw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;

  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [15:0]       cell_t;

  localparam logic [ROW_W:0] ROWS_END   = (ROW_W+1)'(ROWS);
  localparam row_t           LAST_ROW   = row_t'(ROWS - 1);
  localparam col_t           LAST_COL   = col_t'(COLUMNS - 1);
  localparam addr_t          LAST_ADDR  = addr_t'(CELL_COUNT - 1);
  localparam addr_t          ROW_STRIDE = addr_t'(COLUMNS);
  localparam addr_t          LAST_BASE  = addr_t'(CELL_COUNT - COLUMNS);

  localparam cell_t      BLANK_CELL   = 16'h0020;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FLUSH,
    ST_BLANK
  } state_e;

  typedef struct packed {
    op_e         opcode;
    logic [7:0]  char_code;
    logic [7:0]  color_attr;
    logic [12:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  cur_row;
    logic [6:0]  cur_col;
    logic [12:0] cur_linear;
    logic [15:0] read_cell;
  } out_item_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    cell_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  function automatic addr_t cell_addr(row_t row, col_t col);
    cell_addr = addr_t'(int'(row) * COLUMNS + int'(col));
  endfunction

  function automatic logic [12:0] linear_pos(row_t row, col_t col);
    linear_pos = 13'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

// File: src/tcw_screen_ram.sv
// Screen store: one write port, one read port with registered read data.
module tcw_screen_ram (
  input  logic              clk_i,
  input  tcw_pkg::ram_req_t req_i,
  output tcw_pkg::cell_t    rdata_o
);

  tcw_pkg::cell_t mem [tcw_pkg::CELL_COUNT];
  tcw_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tcw_ctrl.sv
// Controller: cursor registers, operation sequencer and store sweeps.
module tcw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  tcw_pkg::in_item_t  in_i,
  input  tcw_pkg::cell_t     rdata_i,
  output tcw_pkg::ram_req_t  req_o,
  output logic               idle_o,
  output logic               res_valid_o,
  output tcw_pkg::out_item_t res_o
);

  tcw_pkg::state_e state_q, state_d;
  tcw_pkg::row_t   row_q, row_d;
  tcw_pkg::col_t   col_q, col_d;
  tcw_pkg::addr_t  ptr_q, ptr_d;
  logic            cp_valid_q, cp_valid_d;
  tcw_pkg::addr_t  cp_addr_q, cp_addr_d;

  logic [tcw_pkg::ROW_W:0] row_nx;
  tcw_pkg::col_t           col_nx;
  tcw_pkg::row_t           bs_row;
  tcw_pkg::col_t           bs_col;
  tcw_pkg::cell_t          res_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tcw_pkg::ST_INIT;
      row_q      <= '0;
      col_q      <= '0;
      ptr_q      <= '0;
      cp_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      ptr_q      <= ptr_d;
      cp_valid_q <= cp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    ptr_d       = ptr_q;
    cp_valid_d  = cp_valid_q;
    cp_addr_d   = cp_addr_q;
    req_o       = '0;
    res_valid_o = 1'b0;
    res_cell    = '0;
    row_nx      = {1'b0, row_q};
    col_nx      = col_q;
    bs_row      = row_q;
    bs_col      = col_q;

    case (state_q)
      tcw_pkg::ST_INIT: begin
        req_o.we    = 1'b1;
        req_o.waddr = ptr_q;
        req_o.wdata = tcw_pkg::BLANK_CELL;
        if (ptr_q == tcw_pkg::LAST_ADDR) begin
          ptr_d   = '0;
          state_d = tcw_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q + tcw_pkg::addr_t'(1);
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (accept_i) begin
          case (in_i.opcode)
            tcw_pkg::OP_PUT: begin
              if (in_i.char_code == tcw_pkg::NEWLINE_CODE) begin
                col_nx = '0;
                row_nx = {1'b0, row_q} + (tcw_pkg::ROW_W+1)'(1);
              end else begin
                req_o.we    = 1'b1;
                req_o.waddr = tcw_pkg::cell_addr(row_q, col_q);
                req_o.wdata = {in_i.color_attr, in_i.char_code};
                if (col_q == tcw_pkg::LAST_COL) begin
                  col_nx = '0;
                  row_nx = {1'b0, row_q} + (tcw_pkg::ROW_W+1)'(1);
                end else begin
                  col_nx = col_q + tcw_pkg::col_t'(1);
                end
              end
              col_d = col_nx;
              if (row_nx == tcw_pkg::ROWS_END) begin
                // Cursor fell off the bottom: scroll first, report afterwards
                row_d      = tcw_pkg::LAST_ROW;
                ptr_d      = tcw_pkg::ROW_STRIDE;
                cp_valid_d = 1'b0;
                state_d    = tcw_pkg::ST_SCROLL;
              end else begin
                row_d       = row_nx[tcw_pkg::ROW_W-1:0];
                res_valid_o = 1'b1;
              end
            end
            tcw_pkg::OP_BACKSPACE: begin
              if (col_q != '0) begin
                bs_col = col_q - tcw_pkg::col_t'(1);
              end else if (row_q != '0) begin
                bs_row = row_q - tcw_pkg::row_t'(1);
                bs_col = tcw_pkg::LAST_COL;
              end
              req_o.we    = 1'b1;
              req_o.waddr = tcw_pkg::cell_addr(bs_row, bs_col);
              req_o.wdata = tcw_pkg::BLANK_CELL;
              row_d       = bs_row;
              col_d       = bs_col;
              res_valid_o = 1'b1;
            end
            tcw_pkg::OP_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              ptr_d   = '0;
              state_d = tcw_pkg::ST_BLANK;
            end
            tcw_pkg::OP_READ: begin
              if (int'(in_i.cell_index) < int'(tcw_pkg::CELL_COUNT)) begin
                req_o.re    = 1'b1;
                req_o.raddr = in_i.cell_index[tcw_pkg::ADDR_W-1:0];
                state_d     = tcw_pkg::ST_READ;
              end else begin
                res_valid_o = 1'b1;
              end
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end

      tcw_pkg::ST_READ: begin
        res_valid_o = 1'b1;
        res_cell    = rdata_i;
        state_d     = tcw_pkg::ST_IDLE;
      end

      tcw_pkg::ST_SCROLL: begin
        // Read one row below, write back the previous read one row up
        req_o.re    = 1'b1;
        req_o.raddr = ptr_q;
        req_o.we    = cp_valid_q;
        req_o.waddr = cp_addr_q;
        req_o.wdata = rdata_i;
        cp_valid_d  = 1'b1;
        cp_addr_d   = ptr_q - tcw_pkg::ROW_STRIDE;
        if (ptr_q == tcw_pkg::LAST_ADDR) begin
          state_d = tcw_pkg::ST_FLUSH;
        end else begin
          ptr_d = ptr_q + tcw_pkg::addr_t'(1);
        end
      end

      tcw_pkg::ST_FLUSH: begin
        req_o.we    = 1'b1;
        req_o.waddr = cp_addr_q;
        req_o.wdata = rdata_i;
        cp_valid_d  = 1'b0;
        ptr_d       = tcw_pkg::LAST_BASE;
        state_d     = tcw_pkg::ST_BLANK;
      end

      tcw_pkg::ST_BLANK: begin
        req_o.we    = 1'b1;
        req_o.waddr = ptr_q;
        req_o.wdata = tcw_pkg::BLANK_CELL;
        if (ptr_q == tcw_pkg::LAST_ADDR) begin
          res_valid_o = 1'b1;
          ptr_d       = '0;
          state_d     = tcw_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q + tcw_pkg::addr_t'(1);
        end
      end

      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == tcw_pkg::ST_IDLE);

  always_comb begin
    res_o.cur_row    = 6'(row_d);
    res_o.cur_col    = 7'(col_d);
    res_o.cur_linear = tcw_pkg::linear_pos(row_d, col_d);
    res_o.read_cell  = res_cell;
  end

endmodule

// File: src/text_console_writer.sv
// Top level of the text console writer: controller, screen store and output register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (tcw_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (tcw_pkg::out_item_t)
//
// Put, backspace and an out-of-range read report from the idle state; a read in range
// reports from the read state. Clear blanks every cell in the blank state, and a put
// that scrolls copies each row one up (scroll, flush) and then blanks the last row;
// both sweep the store through its single write port. After reset a clearing pass
// blanks the store; no input transaction is taken meanwhile.
// The next input transaction is taken only when the output register is free or is being
// emptied in the same cycle; a result left waiting there stalls the input.
module text_console_writer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcw_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcw_pkg::out_item_t out_data_o
);

  logic               ctrl_idle;
  logic               accept;
  logic               res_valid;
  tcw_pkg::out_item_t res;
  tcw_pkg::ram_req_t  ram_req;
  tcw_pkg::cell_t     ram_rdata;

  logic               out_valid_q, out_valid_d;
  tcw_pkg::out_item_t out_data_q;

  // Take a transaction only between operations and when the result slot can be used.
  // Multi-cycle operations start with an empty slot, so their completion never blocks.
  assign in_ready_o = ctrl_idle && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_data_i),
    .rdata_i     (ram_rdata),
    .req_o       (ram_req),
    .idle_o      (ctrl_idle),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tcw_screen_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Output register: load on a finished operation, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload while stalled; no reset needed.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: src/tcw_checker.sv
// Checker: port-level properties of the text console writer, bound to the top level.
module tcw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tcw_pkg::out_item_t out_data_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Never take a transaction while a result is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input taken while result blocked");

  // Cursor stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.cur_row) < int'(tcw_pkg::ROWS)) &&
                    (int'(out_data_o.cur_col) < int'(tcw_pkg::COLUMNS)))
    else $error("cursor off screen");

  // Linear position agrees with row and column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cur_linear ==
      13'(int'(out_data_o.cur_row) * tcw_pkg::COLUMNS + int'(out_data_o.cur_col)))
    else $error("linear cursor position mismatch");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
